>>> design/substring_suffix_extractor_macros.svh
// Assertion macros shared by the substring suffix extractor modules.
`ifndef SUBSTRING_SUFFIX_EXTRACTOR_MACROS_SVH
`define SUBSTRING_SUFFIX_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sse assertion failed");

// Next-cycle implication, disabled during reset.
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sse assertion failed");

`endif

>>> design/sse_pkg.sv
// Shared types and constants for the substring suffix extractor.
package sse_pkg;

  localparam int CHAR_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(1);

  // Pending decision for one accepted byte: a single result or a pattern burst.
  typedef struct packed {
    logic              burst;
    logic [IDX_W-1:0]  len_m1;
    logic [CHAR_W-1:0] ch;
    logic              fnd;
    logic              lst;
  } sse_dec_t;

  function automatic logic [CHAR_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
                                                 input logic [IDX_W-1:0] idx);
    return pat[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

>>> design/sse_cell.sv
// One window cell: holds a text byte, shifts it onward and compares the incoming byte.
module sse_cell
  import sse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  logic              clear,
  input  logic [CHAR_W-1:0] din,
  input  logic [CHAR_W-1:0] pat,
  input  logic              active,
  output logic [CHAR_W-1:0] dout,
  output logic              eq
);

  logic [CHAR_W-1:0] held;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= '0;
    end else if (shift_en) begin
      held <= din;
    end
  end

  // Compare the byte this cell takes on the shift; idle cells never veto a match.
  assign eq   = !active || (din == pat);
  assign dout = held;

endmodule

>>> design/sse_emitter.sv
// Output stage: plays out single results and pattern bursts into the result register.
`include "substring_suffix_extractor_macros.svh"
module sse_emitter
  import sse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              dec_valid,
  input  sse_dec_t          dec,
  input  logic [PAT_W-1:0]  pattern_bytes,
  input  logic              result_stall,
  output logic              dec_take,
  output logic              result_valid,
  output logic [CHAR_W-1:0] out_char,
  output logic              found,
  output logic              result_last
);

  logic [IDX_W-1:0] bidx;
  logic             out_free;
  logic             load;
  logic             burst_end;

  assign out_free  = !result_valid || !result_stall;
  assign load      = dec_valid && out_free;
  assign burst_end = (dec.len_m1 == bidx);
  assign dec_take  = load && (!dec.burst || burst_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      bidx         <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (load && dec.burst) begin
        bidx <= burst_end ? '0 : bidx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (dec.burst) begin
        out_char    <= pat_byte(pattern_bytes, bidx);
        found       <= 1'b1;
        result_last <= dec.lst && burst_end;
      end else begin
        out_char    <= dec.ch;
        found       <= dec.fnd;
        result_last <= dec.lst;
      end
    end
  end

  `SSE_ASSERT_NOW(a_burst_holds_dec, clk, rst, bidx != '0, dec_valid && dec.burst)
  `SSE_ASSERT_NOW(a_burst_idx_in_len, clk, rst, dec_valid && dec.burst, bidx <= dec.len_m1)
  `SSE_ASSERT_NEXT(a_stall_holds, clk, rst, result_valid && result_stall, $stable(out_char))

endmodule

>>> design/substring_suffix_extractor.sv
// Top level of the streaming first-occurrence substring search with suffix output.
// Path: the first result of a byte passes the decision register, then the result register.
// Flow: one text byte per cycle while text_stall is low; a match plays out one result per
// cycle for the clamped length while result_stall is low, and stalls text until the last is loaded.
// Reset (rst, synchronous): pattern 0, length 1, window and sentence state cleared.
`include "substring_suffix_extractor_macros.svh"
module substring_suffix_extractor
  import sse_pkg::*;
#(
  parameter int MAX_PATTERN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // text channel
  input  logic                 text_valid,
  output logic                 text_stall,
  input  logic [CHAR_W-1:0]    text_char,
  input  logic                 text_last,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [CHAR_W-1:0]    out_char,
  output logic                 found,
  output logic                 result_last,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data
);

  localparam int SW = $clog2(MAX_PATTERN + 1);

  // Configuration registers; writes are always taken.
  logic [PAT_W-1:0] pattern_bytes;
  logic [LEN_W-1:0] pattern_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length: zero acts as one, anything past the window saturates.
  logic [LEN_W-1:0] eff_len;
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pattern_length;
    end
  end

  // Sentence state.
  logic [SW-1:0] seen_count;
  logic [SW-1:0] seen_count_next;
  logic          match_done;

  // Decision register between the search and the output stage.
  logic     dec_valid;
  sse_dec_t dec;
  sse_dec_t dec_next;
  logic     dec_take;
  logic     has_result;

  logic accept;
  assign text_stall = dec_valid && !dec_take;
  assign accept     = text_valid && !text_stall;

  // Window: a chain of cells, newest byte in cell 0, shifting toward the far end.
  logic [CHAR_W-1:0]      win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eqv;
  logic                   shift_en;
  logic                   clear;

  assign shift_en = accept && !match_done;
  assign clear    = accept && text_last;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [CHAR_W-1:0] din;
    logic [LEN_W-1:0]  pidx;
    logic              active;

    // Cell j lines up with pattern character eff_len-1-j once shifted.
    assign pidx   = eff_len - LEN_W'(j) - LEN_W'(1);
    assign active = LEN_W'(j) < eff_len;

    if (j == 0) begin : g_head
      assign din = text_char;
    end else begin : g_body
      assign din = win[j-1];
    end

    sse_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shift_en),
      .clear    (clear),
      .din      (din),
      .pat      (pat_byte(pattern_bytes, pidx[IDX_W-1:0])),
      .active   (active),
      .dout     (win[j]),
      .eq       (eqv[j])
    );
  end

  // Count bytes seen, saturating at the window depth.
  assign seen_count_next = (seen_count == SW'(MAX_PATTERN)) ? seen_count
                                                            : seen_count + SW'(1);

  logic hit;
  assign hit = !match_done && (LEN_W'(seen_count_next) >= eff_len) && (&eqv);

  // Decide what the accepted byte produces: pass-through, pattern burst, not-found,
  // or nothing.
  always_comb begin
    dec_next        = '0;
    dec_next.len_m1 = IDX_W'(eff_len - LEN_W'(1));
    dec_next.lst    = text_last;
    has_result      = 1'b0;
    if (match_done) begin
      dec_next.ch  = text_char;
      dec_next.fnd = 1'b1;
      has_result   = 1'b1;
    end else if (hit) begin
      dec_next.burst = 1'b1;
      dec_next.fnd   = 1'b1;
      has_result     = 1'b1;
    end else if (text_last) begin
      has_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
      match_done <= 1'b0;
      dec_valid  <= 1'b0;
    end else begin
      if (accept) begin
        // Drop sentence state at the final byte; otherwise advance the count.
        if (text_last) begin
          seen_count <= '0;
          match_done <= 1'b0;
        end else begin
          if (!match_done) begin
            seen_count <= seen_count_next;
          end
          if (hit) begin
            match_done <= 1'b1;
          end
        end
        dec_valid <= has_result;
      end else if (dec_take) begin
        dec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec <= dec_next;
    end
  end

  sse_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .dec_valid     (dec_valid),
    .dec           (dec),
    .pattern_bytes (pattern_bytes),
    .result_stall  (result_stall),
    .dec_take      (dec_take),
    .result_valid  (result_valid),
    .out_char      (out_char),
    .found         (found),
    .result_last   (result_last)
  );

  // A not-found result always closes its sentence.
  `SSE_ASSERT_NOW(a_notfound_is_last, clk, rst, result_valid && !found, result_last)
  // The final byte of a sentence leaves the sentence state cleared.
  `SSE_ASSERT_NEXT(a_last_clears, clk, rst, accept && text_last, seen_count == '0 && !match_done)
  // A not-found result carries a zero byte.
  `SSE_ASSERT_NOW(a_notfound_zero, clk, rst, result_valid && !found, out_char == '0)

endmodule
